// ----- design/ssa_pkg.sv -----
// ----------------------------------------------------------------------------
// ssa_pkg - shared definitions for the sparse slot allocator
// Operation and status codes, default sizes and the chunk encoders used by
// the bitmap scan.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

	// default table geometry
	localparam int SSA_SLOTS  = 64;
	localparam int SSA_ELEM_W = 32;

	// bitmap scan chunk
	localparam int SCAN_W  = 8;
	localparam int SCAN_IW = $clog2(SCAN_W);

	// field widths of the external words
	localparam int OP_W     = 2;
	localparam int IDX_W    = 6;
	localparam int DATA_W   = 32;
	localparam int FILL_W   = 7;
	localparam int STATUS_W = 2;

	// operation codes (code 3 is a no-op)
	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

	// lowest clear bit of a chunk (caller checks that one exists)
	function automatic logic [SCAN_IW-1:0] low_zero(input logic [SCAN_W-1:0] v);
		logic [SCAN_IW-1:0] r;
		r = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (!v[i]) begin
				r = SCAN_IW'(i);
			end
		end
		return r;
	endfunction

	// highest set bit of a chunk (caller checks that one exists)
	function automatic logic [SCAN_IW-1:0] high_one(input logic [SCAN_W-1:0] v);
		logic [SCAN_IW-1:0] r;
		r = '0;
		for (int i = 0; i < SCAN_W; i++) begin
			if (v[i]) begin
				r = SCAN_IW'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/ssa_ram.sv -----
// ----------------------------------------------------------------------------
// ssa_ram - generic simple dual-port RAM
// One write port, one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/sparse_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// sparse_slot_allocator - first-free slot allocator over a fixed table
//
// Keeps SLOTS slots of ELEMENT_WIDTH-bit data, a used bit per slot and a
// high-water mark one past the highest used slot. An add stores the word in
// the lowest free slot (the slot at the mark when none is free below it)
// and reports the slot; a delete clears a used bit and, when the top slot
// goes, pulls the mark down to just above the highest slot still used; a
// read returns a slot's data and used bit. A full table, a delete on an
// empty table and an out-of-range index are reported in status and leave
// the state alone. One word is worked on at a time: in_ready is low from
// acceptance until the result is handed to the output register, which then
// waits for out_ready while the next word can already be taken. An add
// walks the used bitmap upward one 8-bit chunk at a time from chunk zero
// until a chunk holds a free slot, and through every chunk on a full
// table; a delete of the top slot walks down from the deleted slot's
// chunk until a chunk holds a used slot or chunk zero is reached; a read
// goes through the registered read of the data RAM. A finished result
// waits while the output register still holds one that out_ready has not
// taken. Reading a slot that was never written returns undefined data.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_slot_allocator #(
	parameter int SLOTS         = ssa_pkg::SSA_SLOTS,
	parameter int ELEMENT_WIDTH = ssa_pkg::SSA_ELEM_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request side
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ssa_pkg::OP_W-1:0]       op,
	input  wire logic [ssa_pkg::IDX_W-1:0]      slot_addr,
	input  wire logic [ssa_pkg::DATA_W-1:0]     data_in,
	// result side
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [ssa_pkg::IDX_W-1:0]      slot_out,
	output logic      [ssa_pkg::DATA_W-1:0]     data_out,
	output logic                                slot_in_use,
	output logic      [ssa_pkg::FILL_W-1:0]     fill_level,
	output logic      [ssa_pkg::STATUS_W-1:0]   status
);

	// slot address and mark widths
	localparam int AW   = $clog2(SLOTS);
	localparam int MW   = $clog2(SLOTS + 1);
	// compare width wide enough for the index port, the mark and SLOTS
	localparam int CMPW = ((AW > ssa_pkg::IDX_W) ? AW : ssa_pkg::IDX_W) + 1;
	// scan chunks (at least two so the chunk counter has a bit)
	localparam int NCH_RAW = (SLOTS + ssa_pkg::SCAN_W - 1) / ssa_pkg::SCAN_W;
	localparam int NCH     = (NCH_RAW < 2) ? 2 : NCH_RAW;
	localparam int CW      = $clog2(NCH);
	localparam int PADW    = NCH * ssa_pkg::SCAN_W;
	localparam int FW      = CW + ssa_pkg::SCAN_IW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_DROP,
		S_RDATA,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [SLOTS-1:0]                used_q;
	logic [MW-1:0]                   mark_q;
	logic [CW-1:0]                   chunk_q;
	logic [ELEMENT_WIDTH-1:0]        data_q;
	// pending result
	logic [ssa_pkg::IDX_W-1:0]       res_slot_q;
	logic [ssa_pkg::DATA_W-1:0]      res_data_q;
	logic                            res_use_q;
	logic [ssa_pkg::STATUS_W-1:0]    res_stat_q;
	// output register
	logic                            out_valid_q;
	logic [ssa_pkg::IDX_W-1:0]       out_slot_q;
	logic [ssa_pkg::DATA_W-1:0]      out_data_q;
	logic                            out_use_q;
	logic [ssa_pkg::FILL_W-1:0]      out_fill_q;
	logic [ssa_pkg::STATUS_W-1:0]    out_stat_q;

	// padded bitmap views: pad reads as used for the free search, unused
	// for the downward search
	logic [PADW-1:0] free_view;
	logic [PADW-1:0] used_view;

	genvar g;
	generate
		for (g = 0; g < PADW; g++) begin : g_pad
			if (g < SLOTS) begin : g_real
				assign free_view[g] = used_q[g];
				assign used_view[g] = used_q[g];
			end else begin : g_fill
				assign free_view[g] = 1'b1;
				assign used_view[g] = 1'b0;
			end
		end
	endgenerate

	logic [ssa_pkg::SCAN_W-1:0] cur_free;
	logic [ssa_pkg::SCAN_W-1:0] cur_used;
	logic                       has_free;
	logic                       has_used;
	logic [FW-1:0]              free_pos;
	logic [FW-1:0]              used_pos;
	logic [AW-1:0]              free_slot;
	logic                       last_chunk;
	logic                       first_chunk;

	assign cur_free    = free_view[chunk_q * ssa_pkg::SCAN_W +: ssa_pkg::SCAN_W];
	assign cur_used    = used_view[chunk_q * ssa_pkg::SCAN_W +: ssa_pkg::SCAN_W];
	assign has_free    = ~&cur_free;
	assign has_used    = |cur_used;
	assign free_pos    = {chunk_q, ssa_pkg::low_zero(cur_free)};
	assign used_pos    = {chunk_q, ssa_pkg::high_one(cur_used)};
	assign free_slot   = AW'(free_pos);
	assign last_chunk  = (chunk_q == CW'(NCH - 1));
	assign first_chunk = (chunk_q == '0);

	// request decode
	logic            accept;
	logic [CMPW-1:0] idx_ext;
	logic [CMPW-1:0] mark_ext;
	logic [AW-1:0]   idx_addr;
	logic            idx_beyond_mark;
	logic            idx_beyond_table;
	logic            idx_is_top;

	assign in_ready         = (state_q == S_IDLE);
	assign accept           = in_valid && in_ready;
	assign idx_ext          = CMPW'(slot_addr);
	assign mark_ext         = CMPW'(mark_q);
	assign idx_addr         = AW'(idx_ext);
	assign idx_beyond_mark  = (idx_ext >= mark_ext);
	assign idx_beyond_table = (idx_ext >= CMPW'(SLOTS));
	assign idx_is_top       = ((idx_ext + CMPW'(1)) == mark_ext);

	// data RAM
	logic                     ram_we;
	logic                     ram_re;
	logic [ELEMENT_WIDTH-1:0] ram_rdata;

	assign ram_we = (state_q == S_FIND) && has_free;
	assign ram_re = accept && (op == ssa_pkg::OP_READ) && !idx_beyond_table;

	ssa_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (SLOTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_slot),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (idx_addr),
		.rdata (ram_rdata)
	);

	logic load_out;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			mark_q      <= '0;
			chunk_q     <= '0;
			data_q      <= '0;
			res_slot_q  <= '0;
			res_data_q  <= '0;
			res_use_q   <= 1'b0;
			res_stat_q  <= ssa_pkg::STAT_OK;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_data_q  <= '0;
			out_use_q   <= 1'b0;
			out_fill_q  <= '0;
			out_stat_q  <= ssa_pkg::STAT_OK;
		end else begin
			// a reload in the same cycle keeps the output valid
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q     <= ELEMENT_WIDTH'(data_in);
						res_data_q <= '0;
						unique case (op)
							ssa_pkg::OP_ADD: begin
								res_slot_q <= slot_addr;
								res_use_q  <= 1'b0;
								res_stat_q <= ssa_pkg::STAT_OK;
								chunk_q    <= '0;
								state_q    <= S_FIND;
							end
							ssa_pkg::OP_DEL: begin
								res_slot_q <= slot_addr;
								res_use_q  <= 1'b0;
								priority if (mark_q == '0) begin
									res_stat_q <= ssa_pkg::STAT_EMPTY;
									state_q    <= S_DONE;
								end else if (idx_beyond_mark) begin
									res_stat_q <= ssa_pkg::STAT_RANGE;
									state_q    <= S_DONE;
								end else begin
									res_stat_q       <= ssa_pkg::STAT_OK;
									used_q[idx_addr] <= 1'b0;
									if (idx_is_top) begin
										// walk down from the deleted slot's chunk
										chunk_q <= CW'(idx_addr >> ssa_pkg::SCAN_IW);
										state_q <= S_DROP;
									end else begin
										state_q <= S_DONE;
									end
								end
							end
							ssa_pkg::OP_READ: begin
								res_slot_q <= slot_addr;
								if (idx_beyond_table) begin
									res_use_q  <= 1'b0;
									res_stat_q <= ssa_pkg::STAT_RANGE;
									state_q    <= S_DONE;
								end else begin
									res_use_q  <= used_q[idx_addr];
									res_stat_q <= ssa_pkg::STAT_OK;
									state_q    <= S_RDATA;
								end
							end
							default: begin
								// unused code: empty result
								res_slot_q <= '0;
								res_use_q  <= 1'b0;
								res_stat_q <= ssa_pkg::STAT_OK;
								state_q    <= S_DONE;
							end
						endcase
					end
				end

				S_FIND: begin
					// bits at and above the mark are clear, so the lowest
					// clear bit is the slot to use
					if (has_free) begin
						used_q[free_slot] <= 1'b1;
						if (MW'(free_slot) == mark_q) begin
							mark_q <= mark_q + MW'(1);
						end
						res_slot_q <= ssa_pkg::IDX_W'(free_slot);
						res_use_q  <= 1'b1;
						state_q    <= S_DONE;
					end else if (last_chunk) begin
						res_slot_q <= '0;
						res_stat_q <= ssa_pkg::STAT_FULL;
						state_q    <= S_DONE;
					end else begin
						chunk_q <= chunk_q + CW'(1);
					end
				end

				S_DROP: begin
					if (has_used) begin
						mark_q  <= MW'(used_pos) + MW'(1);
						state_q <= S_DONE;
					end else if (first_chunk) begin
						mark_q  <= '0;
						state_q <= S_DONE;
					end else begin
						chunk_q <= chunk_q - CW'(1);
					end
				end

				S_RDATA: begin
					res_data_q <= ssa_pkg::DATA_W'(ram_rdata);
					state_q    <= S_DONE;
				end

				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_slot_q  <= res_slot_q;
						out_data_q  <= res_data_q;
						out_use_q   <= res_use_q;
						out_fill_q  <= ssa_pkg::FILL_W'(mark_q);
						out_stat_q  <= res_stat_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_out    = out_slot_q;
	assign data_out    = out_data_q;
	assign slot_in_use = out_use_q;
	assign fill_level  = out_fill_q;
	assign status      = out_stat_q;

	// the mark never passes the table size
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= MW'(SLOTS))
		else $error("high-water mark beyond table");

	// between words no slot at or above the mark is in use
	a_mark_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((used_q >> mark_q) == '0))
		else $error("used slot above high-water mark");

	// a full report only comes with a full table
	a_full_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_stat_q == ssa_pkg::STAT_FULL))
			|-> (out_fill_q == ssa_pkg::FILL_W'(SLOTS)))
		else $error("full reported below table size");

endmodule

`default_nettype wire
